// ----- sv/sorted_timer_queue_assert.svh -----
// Assertion macros for the sorted timer queue.
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
`define STQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define STQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/stq_pkg.sv -----
package stq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int TAG_W         = 16;
    localparam int TIME_W        = 16;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_FULL     = 2'd1,
        KIND_EXPIRED  = 2'd2,
        KIND_NONE     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_PUSH = 2'd1,
        OP_DEC  = 2'd2,
        OP_POP  = 2'd3
    } cell_op_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    typedef struct packed {
        cmd_t              command;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] timeout;
    } req_t;

    typedef struct packed {
        kind_t            kind;
        logic [TAG_W-1:0] expired_tag;
        logic             last;
    } rsp_t;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] remaining;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        cell_op_t          op;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] timeout;
    } cell_ctl_t;

endpackage

// ----- sv/stq_cell.sv -----
module stq_cell
    import stq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  entry_t    left,
    input  logic      left_lt,
    input  entry_t    right,
    output entry_t    cur,
    output logic      lt
);

    logic              valid_reg;
    logic              valid_next;
    logic [TIME_W-1:0] remaining_reg;
    logic [TIME_W-1:0] remaining_next;
    logic [TAG_W-1:0]  tag_reg;
    logic [TAG_W-1:0]  tag_next;

    assign cur = '{valid: valid_reg, remaining: remaining_reg, tag: tag_reg};
    assign lt  = valid_reg && (remaining_reg < ctl.timeout);

    always_comb
    begin
        valid_next     = valid_reg;
        remaining_next = remaining_reg;
        tag_next       = tag_reg;
        unique case (ctl.op)
            OP_HOLD:
            begin
            end
            OP_PUSH:
            begin
                if (!lt)
                begin
                    if (left_lt)
                    begin
                        valid_next     = 1'b1;
                        remaining_next = ctl.timeout;
                        tag_next       = ctl.tag;
                    end
                    else
                    begin
                        valid_next     = left.valid;
                        remaining_next = left.remaining;
                        tag_next       = left.tag;
                    end
                end
            end
            OP_DEC:
            begin
                if (valid_reg && (remaining_reg != '0))
                    remaining_next = remaining_reg - TIME_W'(1);
            end
            OP_POP:
            begin
                valid_next     = right.valid;
                remaining_next = right.remaining;
                tag_next       = right.tag;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        remaining_reg <= remaining_next;
        tag_reg       <= tag_next;
    end

endmodule

// ----- sv/sorted_timer_queue.sv -----
// Sorted timer queue: holds up to DEPTH timers in a chain of cells, ordered by ticks
// remaining, newest first among equals. A push answers accepted or full; a timeout of
// zero counts as one. A tick first counts every cell down, then each expired timer
// shifts out of the head of the chain with its own answer, or the single nothing-expired
// answer is given; the drain waits while the output register is still held. Results
// leave through an output register, so a push is taken while the previous result is
// being transferred.
`include "sorted_timer_queue_assert.svh"

module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    state_t    state_reg;
    state_t    state_next;
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    rsp_t      rsp_reg;
    rsp_t      rsp_next;
    cell_ctl_t ctl;
    entry_t    cells [DEPTH];
    logic      lts [DEPTH];
    logic [DEPTH-1:0] valid_vec;
    logic      can_load;
    logic      full;
    logic      head_exp;
    logic      next_exp;
    logic      req_xfer;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_lt;
            if (gi == 0)
            begin : g_head
                assign left_e  = '0;
                assign left_lt = 1'b1;
            end
            else
            begin : g_body
                assign left_e  = cells[gi-1];
                assign left_lt = lts[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = cells[gi+1];
            end
            stq_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .left    (left_e),
                .left_lt (left_lt),
                .right   (right_e),
                .cur     (cells[gi]),
                .lt      (lts[gi])
            );
            assign valid_vec[gi] = cells[gi].valid;
        end
    endgenerate

    assign can_load  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && can_load;
    assign req_xfer  = req_valid && req_ready;
    assign full      = cells[DEPTH-1].valid;
    assign head_exp  = cells[0].valid && (cells[0].remaining == '0);
    assign next_exp  = cells[1].valid && (cells[1].remaining == '0);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ctl.op         = OP_HOLD;
        ctl.tag        = req.tag;
        ctl.timeout    = (req.timeout == '0) ? TIME_W'(1) : req.timeout;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    if (req.command == CMD_PUSH)
                    begin
                        ctl.op         = full ? OP_HOLD : OP_PUSH;
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{kind: (full ? KIND_FULL : KIND_ACCEPTED),
                                           expired_tag: '0, last: 1'b1};
                    end
                    else
                    begin
                        ctl.op     = OP_DEC;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (can_load)
                begin
                    rsp_valid_next = 1'b1;
                    if (head_exp)
                    begin
                        ctl.op   = OP_POP;
                        rsp_next = '{kind: KIND_EXPIRED, expired_tag: cells[0].tag,
                                     last: !next_exp};
                        if (!next_exp)
                            state_next = ST_IDLE;
                    end
                    else
                    begin
                        rsp_next   = '{kind: KIND_NONE, expired_tag: '0, last: 1'b1};
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    `STQ_ASSERT_IMPL(a_prefix, clk, rst_n, 1'b1, (valid_vec & (valid_vec + DEPTH'(1))) == '0)
    `STQ_ASSERT_IMPL(a_drain_blocks, clk, rst_n, state_reg == ST_DRAIN, !req_ready)
    `STQ_ASSERT_NEXT(a_tick_drain, clk, rst_n,
                     req_xfer && req.command == CMD_TICK,
                     state_reg == ST_DRAIN && !rsp_valid_reg)
    `STQ_ASSERT_IMPL(a_last, clk, rst_n, rsp_valid_reg && rsp_reg.kind != KIND_EXPIRED, rsp_reg.last)

endmodule
